// File: sv/window_spread_motion_alarm_core_assert.svh
// ============================================================================
// Window spread motion alarm: assertion macros
// Concurrent assertion forms used by the alarm core.
// ============================================================================
`ifndef WINDOW_SPREAD_MOTION_ALARM_CORE_ASSERT_SVH
`define WINDOW_SPREAD_MOTION_ALARM_CORE_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define SWMA_ASSERT_IMP(label, clk_i, rst_ni, ante, cons, msg) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define SWMA_ASSERT_NXT(label, clk_i, rst_ni, ante, cons, msg) \
    label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/swma_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Window spread motion alarm package
// Types and fixed constants shared by the alarm core and its submodules.
// ============================================================================
package swma_pkg;

    localparam int TH_W = 8;
    localparam int TH2_W = 2 * TH_W;
    localparam logic [TH_W-1:0] TH_RESET = 8'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SQ_NEW,
        ST_SQ_OLD,
        ST_EVAL,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ring_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

// File: sv/swma_ring.sv
`timescale 1ns / 1ps
// ============================================================================
// Sample ring memory
// One write port and one registered read port holding the window samples.
// ============================================================================
module swma_ring #(
    parameter int DEPTH  = 35,
    parameter int DATA_W = 12
) (
    input  logic                     clk,
    input  swma_pkg::ring_ctl_t      ctl,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [DATA_W-1:0]        wr_data,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/swma_mul.sv
`timescale 1ns / 1ps
// ============================================================================
// Bit-serial multiplier
// Shift-and-add product, one multiplier bit per cycle, ending when the
// remaining multiplier bits are all zero.
// ============================================================================
module swma_mul #(
    parameter int A_W = 31,
    parameter int B_W = 18,
    parameter int P_W = 36
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [A_W-1:0]        a_in,
    input  logic [B_W-1:0]        b_in,
    output logic [P_W-1:0]        p,
    output swma_pkg::mul_stat_t   stat
);

    logic           busy_reg;
    logic [P_W-1:0] a_reg;
    logic [B_W-1:0] b_reg;
    logic [P_W-1:0] p_reg;
    logic           b_zero;

    assign b_zero = (b_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && b_zero)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= P_W'(a_in);
            b_reg <= b_in;
            p_reg <= '0;
        end
        else if (busy_reg && !b_zero)
        begin
            if (b_reg[0])
            begin
                p_reg <= p_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign p         = p_reg;
    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && b_zero;

endmodule

// File: sv/window_spread_motion_alarm_core.sv
`timescale 1ns / 1ps
// Each item squares its new sample and, once the window is full, the evicted sample on the
// bit-serial multiplier; a rising edge with two or more samples adds the spread-test products.
// A new item is taken only in the idle state, once the last result is in the output register.
// Reset (rst_n, asynchronous, active low) empties the window, clears the sums, the motion
// history and the internal warning flag, and sets the threshold to 1.
// ============================================================================
// Window spread motion alarm core
// Keeps a sliding window of distance samples with running sums and, on a motion
// rising edge, sets the warning when the sample spread exceeds the threshold, else clears it.
// ============================================================================
`include "window_spread_motion_alarm_core_assert.svh"

module window_spread_motion_alarm_core #(
    parameter int WINDOW      = 35,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        motion_level,
    input  logic [SAMPLE_BITS-1:0]      distance_cm,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        warning,
    output logic                        edge_seen,
    input  logic                        cfg_wr_en,
    input  logic [swma_pkg::TH_W-1:0]   cfg_wr_data
);

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS + CNT_W;
    localparam int PROD_W = 2 * SUM_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int NN_W   = 2 * CNT_W;

    localparam logic [CNT_W-1:0] WIN_CNT   = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW - 1);
    localparam logic [IDX_W-1:0] SLOT_ONE  = IDX_W'(1);

    swma_pkg::state_t state_reg;
    swma_pkg::state_t state_next;

    logic [CNT_W-1:0]          fill_count_reg;
    logic [IDX_W-1:0]          oldest_slot_reg;
    logic [SUM_W-1:0]          sum_reg;
    logic [SQ_W-1:0]           sumsq_reg;
    logic                      prev_motion_reg;
    logic                      warning_flag_reg;
    logic [swma_pkg::TH_W-1:0] threshold_reg;
    logic                      out_valid_reg;

    logic [SAMPLE_BITS-1:0]     sample_reg;
    logic                       edge_reg;
    logic                       evict_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic [swma_pkg::TH2_W-1:0] tmp_reg;
    logic                       out_warning_reg;
    logic                       out_edge_reg;

    logic                     full;
    logic                     out_free;
    logic                     mul_start;
    logic [SQ_W-1:0]          mul_a;
    logic [SUM_W-1:0]         mul_b;
    logic [PROD_W-1:0]        mul_p;
    swma_pkg::mul_stat_t      mul_stat;
    swma_pkg::ring_ctl_t      ring_ctl;
    logic [IDX_W-1:0]         ring_wr_addr;
    logic [SAMPLE_BITS-1:0]   ring_rd_data;
    logic signed [ACC_W-1:0]  acc_final;
    logic signed [ACC_W-1:0]  prod_ext;

    assign full         = (fill_count_reg == WIN_CNT);
    assign out_free     = !out_valid_reg || out_ready;
    assign ring_wr_addr = full ? oldest_slot_reg : fill_count_reg[IDX_W-1:0];
    assign prod_ext     = signed'({2'b00, mul_p});
    assign acc_final    = acc_reg - prod_ext;

    swma_ring #(
        .DEPTH  (WINDOW),
        .DATA_W (SAMPLE_BITS)
    ) u_ring (
        .clk     (clk),
        .ctl     (ring_ctl),
        .wr_addr (ring_wr_addr),
        .rd_addr (oldest_slot_reg),
        .wr_data (distance_cm),
        .rd_data (ring_rd_data)
    );

    swma_mul #(
        .A_W (SQ_W),
        .B_W (SUM_W),
        .P_W (PROD_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a_in  (mul_a),
        .b_in  (mul_b),
        .p     (mul_p),
        .stat  (mul_stat)
    );

    always_comb
    begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        ring_ctl   = '0;
        case (state_reg)
            swma_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    ring_ctl.wr_en = 1'b1;
                    ring_ctl.rd_en = full;
                    state_next     = swma_pkg::ST_LOAD;
                end
            end
            swma_pkg::ST_LOAD:
            begin
                mul_start  = 1'b1;
                mul_a      = SQ_W'(sample_reg);
                mul_b      = SUM_W'(sample_reg);
                state_next = swma_pkg::ST_SQ_NEW;
            end
            swma_pkg::ST_SQ_NEW:
            begin
                if (mul_stat.done)
                begin
                    if (evict_reg)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = SQ_W'(ring_rd_data);
                        mul_b      = SUM_W'(ring_rd_data);
                        state_next = swma_pkg::ST_SQ_OLD;
                    end
                    else
                    begin
                        state_next = swma_pkg::ST_EVAL;
                    end
                end
            end
            swma_pkg::ST_SQ_OLD:
            begin
                if (mul_stat.done)
                begin
                    state_next = swma_pkg::ST_EVAL;
                end
            end
            swma_pkg::ST_EVAL:
            begin
                if (edge_reg && (fill_count_reg >= CNT_TWO))
                begin
                    mul_start  = 1'b1;
                    mul_a      = sumsq_reg;
                    mul_b      = SUM_W'(fill_count_reg);
                    state_next = swma_pkg::ST_M1;
                end
                else
                begin
                    state_next = swma_pkg::ST_DONE;
                end
            end
            swma_pkg::ST_M1:
            begin
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = SQ_W'(sum_reg);
                    mul_b      = sum_reg;
                    state_next = swma_pkg::ST_M2;
                end
            end
            swma_pkg::ST_M2:
            begin
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = SQ_W'(threshold_reg);
                    mul_b      = SUM_W'(threshold_reg);
                    state_next = swma_pkg::ST_M3;
                end
            end
            swma_pkg::ST_M3:
            begin
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = SQ_W'(fill_count_reg);
                    mul_b      = SUM_W'(fill_count_reg - CNT_ONE);
                    state_next = swma_pkg::ST_M4;
                end
            end
            swma_pkg::ST_M4:
            begin
                if (mul_stat.done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = SQ_W'(tmp_reg);
                    mul_b      = SUM_W'(mul_p[NN_W-1:0]);
                    state_next = swma_pkg::ST_M5;
                end
            end
            swma_pkg::ST_M5:
            begin
                if (mul_stat.done)
                begin
                    state_next = swma_pkg::ST_DONE;
                end
            end
            swma_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = swma_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swma_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg   <= '0;
            oldest_slot_reg  <= '0;
            sum_reg          <= '0;
            sumsq_reg        <= '0;
            prev_motion_reg  <= 1'b0;
            warning_flag_reg <= 1'b0;
            threshold_reg    <= swma_pkg::TH_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                threshold_reg <= cfg_wr_data;
            end
            if ((state_reg == swma_pkg::ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                swma_pkg::ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        prev_motion_reg <= motion_level;
                        if (full)
                        begin
                            oldest_slot_reg <= (oldest_slot_reg == LAST_SLOT) ?
                                               '0 : oldest_slot_reg + SLOT_ONE;
                        end
                        else
                        begin
                            fill_count_reg <= fill_count_reg + CNT_ONE;
                        end
                    end
                end
                swma_pkg::ST_LOAD:
                begin
                    sum_reg <= sum_reg + SUM_W'(sample_reg)
                               - (evict_reg ? SUM_W'(ring_rd_data) : '0);
                end
                swma_pkg::ST_SQ_NEW:
                begin
                    if (mul_stat.done)
                    begin
                        sumsq_reg <= sumsq_reg + mul_p[SQ_W-1:0];
                    end
                end
                swma_pkg::ST_SQ_OLD:
                begin
                    if (mul_stat.done)
                    begin
                        sumsq_reg <= sumsq_reg - mul_p[SQ_W-1:0];
                    end
                end
                swma_pkg::ST_EVAL:
                begin
                    if (edge_reg && (fill_count_reg < CNT_TWO))
                    begin
                        warning_flag_reg <= 1'b0;
                    end
                end
                swma_pkg::ST_M5:
                begin
                    if (mul_stat.done)
                    begin
                        warning_flag_reg <= !acc_final[ACC_W-1] && (acc_final != '0);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            swma_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_reg <= distance_cm;
                    edge_reg   <= !prev_motion_reg && motion_level;
                    evict_reg  <= full;
                end
            end
            swma_pkg::ST_M1:
            begin
                if (mul_stat.done)
                begin
                    acc_reg <= prod_ext;
                end
            end
            swma_pkg::ST_M2:
            begin
                if (mul_stat.done)
                begin
                    acc_reg <= acc_final;
                end
            end
            swma_pkg::ST_M3:
            begin
                if (mul_stat.done)
                begin
                    tmp_reg <= mul_p[swma_pkg::TH2_W-1:0];
                end
            end
            swma_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_warning_reg <= warning_flag_reg;
                    out_edge_reg    <= edge_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign in_ready  = (state_reg == swma_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign warning   = out_warning_reg;
    assign edge_seen = out_edge_reg;

    // The ring only starts to rotate once the window is full.
    `SWMA_ASSERT_IMP(a_slot_moves_when_full, clk, rst_n,
        oldest_slot_reg != '0, fill_count_reg == WIN_CNT,
        "Oldest slot moved before the window was full.")

    // A new result is only published from the completion state.
    `SWMA_ASSERT_IMP(a_result_from_done, clk, rst_n,
        $rose(out_valid_reg), $past(state_reg == swma_pkg::ST_DONE),
        "Result published outside the completion state.")

    // The warning only changes while a rising motion edge is evaluated.
    `SWMA_ASSERT_IMP(a_warning_on_edge, clk, rst_n,
        !$stable(warning_flag_reg), $past(edge_reg),
        "Warning changed without a motion rising edge.")

    // Every waiting state has a multiplication in flight.
    `SWMA_ASSERT_NXT(a_mul_started, clk, rst_n,
        mul_start, mul_stat.busy && (state_reg != swma_pkg::ST_IDLE),
        "Multiplier not busy after a start.")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Window spread motion alarm core testbench
// Drives motion and distance transactions through the valid/ready channels
// and checks each result against a built-in sliding-window spread predictor or
// a fixed table value. A short stimulus table comes first, then random bursts
// under several thresholds and idle patterns, with a long output hold-off.
// ============================================================================
module tb_top;

    localparam int WINDOW          = 35;
    localparam int SAMPLE_BITS     = 12;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;
    localparam int DIRECTED_ROWS   = 18;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 175;
    localparam int IDLE_LIGHT_PCT  = 6;
    localparam int IDLE_HEAVY_PCT  = 71;
    localparam int RX_HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES    = 100;
    localparam int TOGGLE_PCT      = 30;

    typedef enum int {
        STYLE_FLAT,
        STYLE_CLUSTER,
        STYLE_EXTREME,
        STYLE_NOISE
    } burst_style_t;

    typedef struct packed {
        logic warning;
        logic edge_seen;
    } alarm_result_t;

    typedef struct packed {
        logic                   motion;
        logic [SAMPLE_BITS-1:0] distance;
        logic                   fixed_exp;
        alarm_result_t          result;
    } stim_row_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      motion_level;
    logic [SAMPLE_BITS-1:0]    distance_cm;
    logic                      out_valid;
    logic                      out_ready;
    logic                      warning;
    logic                      edge_seen;
    logic                      cfg_wr_en;
    logic [swma_pkg::TH_W-1:0] cfg_wr_data;

    logic [SAMPLE_BITS-1:0]    win_samples [WINDOW];
    int unsigned               win_count;
    int unsigned               win_head;
    longint unsigned           win_sum;
    longint unsigned           win_sq_sum;
    logic                      last_motion;
    logic                      alarm_flag;
    logic [swma_pkg::TH_W-1:0] spread_th;

    alarm_result_t          pending_alarms [$];
    int unsigned            error_count = 0;
    int unsigned            tx_idle_pct = 0;
    int unsigned            rx_idle_pct = 0;
    bit                     rx_hold_pending = 1'b0;

    stim_row_t stim_rows [DIRECTED_ROWS] = '{
        '{1'b1, 12'd0,    1'b1, '{1'b0, 1'b1}},
        '{1'b0, 12'd4095, 1'b1, '{1'b0, 1'b0}},
        '{1'b1, 12'd4095, 1'b1, '{1'b1, 1'b1}},
        '{1'b1, 12'd4095, 1'b1, '{1'b1, 1'b0}},
        '{1'b0, 12'd0,    1'b1, '{1'b1, 1'b0}},
        '{1'b0, 12'd2048, 1'b0, '{1'b0, 1'b0}},
        '{1'b1, 12'd2048, 1'b0, '{1'b0, 1'b0}},
        '{1'b1, 12'd0,    1'b0, '{1'b0, 1'b0}},
        '{1'b1, 12'd4095, 1'b0, '{1'b0, 1'b0}},
        '{1'b0, 12'd1365, 1'b0, '{1'b0, 1'b0}},
        '{1'b1, 12'd2730, 1'b0, '{1'b0, 1'b0}},
        '{1'b0, 12'd4094, 1'b0, '{1'b0, 1'b0}},
        '{1'b1, 12'd1,    1'b0, '{1'b0, 1'b0}},
        '{1'b0, 12'd4095, 1'b0, '{1'b0, 1'b0}},
        '{1'b0, 12'd4095, 1'b0, '{1'b0, 1'b0}},
        '{1'b1, 12'd0,    1'b0, '{1'b0, 1'b0}},
        '{1'b0, 12'd0,    1'b0, '{1'b0, 1'b0}},
        '{1'b0, 12'd0,    1'b0, '{1'b0, 1'b0}}
    };

    window_spread_motion_alarm_core #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .motion_level (motion_level),
        .distance_cm  (distance_cm),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .warning      (warning),
        .edge_seen    (edge_seen),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #6 clk = ~clk;

    function automatic alarm_result_t step_alarm(input logic motion,
                                                 input logic [SAMPLE_BITS-1:0] distance);
        alarm_result_t   res;
        logic            rising;
        longint unsigned s;
        longint unsigned old;
        longint unsigned n;
        longint unsigned th;
        longint unsigned lhs;
        longint unsigned rhs;
        s = distance;
        rising = !last_motion && motion;
        if (win_count == WINDOW)
        begin
            old = win_samples[win_head];
            win_sum = win_sum - old;
            win_sq_sum = win_sq_sum - old * old;
            win_samples[win_head] = distance;
            win_head = (win_head + 1) % WINDOW;
        end
        else
        begin
            win_samples[(win_head + win_count) % WINDOW] = distance;
            win_count++;
        end
        win_sum = win_sum + s;
        win_sq_sum = win_sq_sum + s * s;
        if (rising)
        begin
            n = win_count;
            th = spread_th;
            if (n < 2)
            begin
                alarm_flag = 1'b0;
            end
            else
            begin
                lhs = n * win_sq_sum;
                rhs = win_sum * win_sum + th * th * n * (n - 1);
                alarm_flag = (lhs > rhs);
            end
        end
        last_motion = motion;
        res.warning = alarm_flag;
        res.edge_seen = rising;
        return res;
    endfunction

    task automatic send_item(input logic motion, input logic [SAMPLE_BITS-1:0] distance,
                             input logic fixed_exp, input alarm_result_t fixed_res);
        alarm_result_t predicted;
        while ($urandom_range(99, 0) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        motion_level <= motion;
        distance_cm <= distance;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = step_alarm(motion, distance);
        pending_alarms.insert(pending_alarms.size(), fixed_exp ? fixed_res : predicted);
    endtask

    task automatic write_threshold(input logic [swma_pkg::TH_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        spread_th = value;
    endtask

    task automatic wait_for_results();
        while (pending_alarms.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_bursts(input int unsigned count);
        int unsigned  sent;
        int unsigned  burst_len;
        int unsigned  pick;
        int unsigned  base;
        int unsigned  spread;
        int           v;
        logic         motion;
        burst_style_t style;
        sent = 0;
        motion = 1'b0;
        base = $urandom_range(SAMPLE_MAX, 0);
        while (sent < count)
        begin
            burst_len = $urandom_range(40, 1);
            pick = $urandom_range(9, 0);
            if (pick < 3)
                style = STYLE_FLAT;
            else if (pick < 7)
                style = STYLE_CLUSTER;
            else if (pick < 9)
                style = STYLE_EXTREME;
            else
                style = STYLE_NOISE;
            if ($urandom_range(99, 0) < 30)
                base = $urandom_range(SAMPLE_MAX, 0);
            spread = $urandom_range(2 * spread_th + 2, 0);
            for (int k = 0; k < burst_len && sent < count; k++)
            begin
                if ($urandom_range(99, 0) < TOGGLE_PCT)
                    motion = ~motion;
                case (style)
                    STYLE_FLAT:    v = base;
                    STYLE_CLUSTER: v = int'(base) + int'($urandom_range(2 * spread, 0))
                                       - int'(spread);
                    STYLE_EXTREME: v = $urandom_range(1, 0) ? SAMPLE_MAX : 0;
                    default:
                    begin
                        v = $urandom_range(SAMPLE_MAX, 0);
                        motion = 1'($urandom_range(1, 0));
                    end
                endcase
                if (v < 0)
                    v = 0;
                if (v > SAMPLE_MAX)
                    v = SAMPLE_MAX;
                send_item(motion, v[SAMPLE_BITS-1:0], 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        alarm_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_alarms.size() == 0)
            begin
                $error("unexpected result transaction: warning %0d, edge_seen %0d",
                       warning, edge_seen);
                error_count++;
            end
            else
            begin
                exp_res = pending_alarms[0];
                pending_alarms.delete(0);
                if (warning !== exp_res.warning)
                begin
                    $error("warning mismatch: expected %0d, actual %0d",
                           exp_res.warning, warning);
                    error_count++;
                end
                if (edge_seen !== exp_res.edge_seen)
                begin
                    $error("edge_seen mismatch: expected %0d, actual %0d",
                           exp_res.edge_seen, edge_seen);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_pending)
            begin
                rx_hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
        end
    end

    initial
    begin
        #10_000_000;
        $display("FAIL window_spread_motion_alarm_core");
        $finish;
    end

    initial
    begin
        int unsigned th_plan [RANDOM_PHASES];
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        motion_level <= 1'b0;
        distance_cm <= '0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        win_count = 0;
        win_head = 0;
        win_sum = 0;
        win_sq_sum = 0;
        last_motion = 1'b0;
        alarm_flag = 1'b0;
        spread_th = swma_pkg::TH_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_idle_pct = IDLE_LIGHT_PCT;
        rx_idle_pct = IDLE_HEAVY_PCT;
        for (int r = 0; r < DIRECTED_ROWS; r++)
            send_item(stim_rows[r].motion, stim_rows[r].distance,
                      stim_rows[r].fixed_exp, stim_rows[r].result);
        in_valid <= 1'b0;
        wait_for_results();

        th_plan = '{0, 255, $urandom_range(40, 2), 1, $urandom_range(255, 0),
                    $urandom_range(20, 1)};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_threshold(swma_pkg::TH_W'(th_plan[p]));
            if (p < 2)
            begin
                tx_idle_pct = IDLE_LIGHT_PCT;
                rx_idle_pct = IDLE_HEAVY_PCT;
            end
            else if (p < 4)
            begin
                tx_idle_pct = IDLE_HEAVY_PCT;
                rx_idle_pct = IDLE_LIGHT_PCT;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (p == 1)
                rx_hold_pending = 1'b1;
            send_random_bursts(ITEMS_PER_PHASE);
            in_valid <= 1'b0;
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_alarms.size() == 0)
            $display("PASS window_spread_motion_alarm_core");
        else
            $display("FAIL window_spread_motion_alarm_core");
        $finish;
    end

endmodule
